### rtl/lpht_pkg.sv
// lpht_pkg: shared sizes, codes and controller/datapath handshake structs
// for the linear probing hash table; no dependencies
package lpht_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int KEY_BYTES   = 8;

   // fixed field widths
   localparam int MODE_W     = 2;
   localparam int KEY_W      = 64;
   localparam int LEN_W      = 4;
   localparam int DATE_W     = 27;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 7;
   localparam int USED_W     = 8;
   localparam int SLOTS_W    = 8;

   localparam logic [SLOTS_W-1:0] SLOTS_RESET = 8'd107;

   // derived sizes
   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W     = 8 + $clog2(KEY_BYTES);
   localparam int MOD_STEPS = SUM_W / 2;
   localparam int K_TOP     = 2 * MOD_STEPS - 1;
   localparam int K_W       = $clog2(K_TOP + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      RES_INSERTED  = 3'd0,
      RES_FOUND     = 3'd1,
      RES_NOT_FOUND = 3'd2,
      RES_DELETED   = 3'd3,
      RES_FULL      = 3'd4
   } result_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_GONE  = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic load;
      logic sum;
      logic mod_step;
      logic rd_en;
      logic check;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic chk_done;
   } sts_type;

   // number of slots in use, clamped to 2 .. TABLE_DEPTH
   function automatic logic [CNT_W-1:0] live_slots(input logic [SLOTS_W-1:0] v);
      int t;
      t = int'(v);
      if (t < 2) t = 2;
      if (t > TABLE_DEPTH) t = TABLE_DEPTH;
      return CNT_W'(t);
   endfunction

endpackage

### rtl/lpht_ctrl.sv
// lpht_ctrl: request sequencer for the hash table (hash, probe, respond)
// depends on lpht_pkg
module lpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  lpht_pkg::sts_type sts,
   output lpht_pkg::cmd_type cmd
);
   import lpht_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SUM    = 6'b000010,
      ST_MOD    = 6'b000100,
      ST_READ   = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_FINISH = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.chk_done ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            // output slot free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/lpht_datapath.sv
// lpht_datapath: request registers, hash remainder unit, probe counters,
// slot memories and result registers; depends on lpht_pkg
module lpht_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lpht_pkg::SLOTS_W-1:0]          csr_wr_data,
   input  logic [lpht_pkg::MODE_W-1:0]           req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]            req_key_text,
   input  logic [lpht_pkg::LEN_W-1:0]            req_key_length,
   input  logic [lpht_pkg::DATE_W-1:0]           req_admission_date,
   input  logic [lpht_pkg::DATE_W-1:0]           req_birth_date,
   input  lpht_pkg::cmd_type                     cmd,
   output lpht_pkg::sts_type                     sts,
   output logic [lpht_pkg::STATUS_W-1:0]         rsp_status,
   output logic [lpht_pkg::SLOT_OUT_W-1:0]       rsp_slot_index,
   output logic [lpht_pkg::DATE_W-1:0]           rsp_found_admission,
   output logic [lpht_pkg::DATE_W-1:0]           rsp_found_birth,
   output logic [lpht_pkg::USED_W-1:0]           rsp_used_count
);
   import lpht_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LEN_W-1:0]  len;
      logic [DATE_W-1:0] adm;
      logic [DATE_W-1:0] birth;
   } rec_type;

   // one restoring remainder step: subtract n << k when it fits
   function automatic logic [SUM_W-1:0] rem_step(input logic [SUM_W-1:0] r,
                                                  input logic [CNT_W-1:0] n,
                                                  input logic [K_W-1:0]   k);
      logic [SUM_W+CNT_W-1:0] d;
      logic [SUM_W+CNT_W-1:0] rx;
      d  = (SUM_W + CNT_W)'(n) << k;
      rx = (SUM_W + CNT_W)'(r);
      if (rx >= d) rx = rx - d;
      return SUM_W'(rx);
   endfunction

   // configuration and captured request
   logic [SLOTS_W-1:0] slots_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [DATE_W-1:0]  adm_ff, birth_ff;

   // hash and probe
   logic [SUM_W-1:0]   rem_ff;
   logic [K_W-1:0]     k_ff;
   logic [IDX_W-1:0]   probe_ff;
   logic [CNT_W-1:0]   try_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   // memories and read registers
   logic [1:0]         st_mem [TABLE_DEPTH];
   rec_type            rec_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [1:0]         rd_state_ff;
   logic               rd_vld_ff;
   rec_type            rd_rec_ff;

   // result registers
   logic [STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]    res_idx_ff;
   logic [DATE_W-1:0]   res_fa_ff, res_fb_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [SLOT_OUT_W-1:0] out_idx_ff;
   logic [DATE_W-1:0]   out_fa_ff, out_fb_ff;
   logic [USED_W-1:0]   out_used_ff;

   logic [LEN_W-1:0]   len_clamp;
   logic [KEY_W-1:0]   key_mask;
   logic [SUM_W-1:0]   byte_sum;
   logic [SUM_W-1:0]   rem_a, rem_b;
   logic [IDX_W-1:0]   probe_next;
   logic               last_try;
   logic [1:0]         slot_st;
   logic               key_match;
   logic               chk_done;
   logic [STATUS_W-1:0] chk_status;
   logic               st_we, rec_we;
   logic [1:0]         st_wdata;

   assign len_clamp = (req_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                           : req_key_length;

   always_comb begin
      key_mask = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (LEN_W'(b) < len_clamp) key_mask[8*b +: 8] = req_key_text[8*b +: 8];
      end
   end

   // hash equals the plain byte sum modulo the slot count
   always_comb begin
      byte_sum = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         byte_sum = byte_sum + SUM_W'(key_ff[8*b +: 8]);
      end
   end

   assign rem_a = rem_step(rem_ff, n_ff, k_ff);
   assign rem_b = rem_step(rem_a, n_ff, k_ff - K_W'(1));
   assign sts.mod_last = (k_ff == K_W'(1));

   assign probe_next = (CNT_W'(probe_ff) + CNT_W'(1) == n_ff) ? '0
                                                              : probe_ff + IDX_W'(1);
   assign last_try   = (try_ff + CNT_W'(1) == n_ff);

   assign slot_st   = rd_vld_ff ? rd_state_ff : SLOT_EMPTY;
   assign key_match = (slot_st == SLOT_USED) && (rd_rec_ff.len == len_ff) &&
                      (rd_rec_ff.key == key_ff);

   always_comb begin
      chk_done   = 1'b0;
      chk_status = RES_NOT_FOUND;
      st_we      = 1'b0;
      rec_we     = 1'b0;
      st_wdata   = SLOT_USED;
      count_in   = count_ff;
      case (mode_ff)
         MODE_INSERT: begin
            if (slot_st != SLOT_USED) begin
               chk_done   = 1'b1;
               chk_status = RES_INSERTED;
               st_we      = 1'b1;
               rec_we     = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end else if (last_try) begin
               chk_done   = 1'b1;
               chk_status = RES_FULL;
            end
         end
         MODE_SEARCH, MODE_DELETE: begin
            if (slot_st == SLOT_EMPTY) begin
               chk_done = 1'b1;
            end else if (key_match) begin
               chk_done = 1'b1;
               if (mode_ff == MODE_SEARCH) begin
                  chk_status = RES_FOUND;
               end else begin
                  chk_status = RES_DELETED;
                  st_we      = 1'b1;
                  st_wdata   = SLOT_GONE;
                  if (count_ff != '0) count_in = count_ff - CNT_W'(1);
               end
            end else if (last_try) begin
               chk_done = 1'b1;
            end
         end
         default: chk_done = 1'b1;
      endcase
   end

   assign sts.chk_done = chk_done;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) slots_ff <= csr_wr_data;
         if (cmd.check) begin
            count_ff <= count_in;
            if (st_we) valid_ff[probe_ff] <= 1'b1;
         end
      end
   end

   // request, hash and probe registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff     <= live_slots(slots_ff);
         mode_ff  <= req_mode;
         key_ff   <= key_mask;
         len_ff   <= len_clamp;
         adm_ff   <= req_admission_date;
         birth_ff <= req_birth_date;
      end
      if (cmd.sum) begin
         rem_ff <= byte_sum;
         k_ff   <= K_W'(K_TOP);
      end
      if (cmd.mod_step) begin
         rem_ff <= rem_b;
         k_ff   <= k_ff - K_W'(2);
         if (sts.mod_last) begin
            probe_ff <= IDX_W'(rem_b);
            try_ff   <= '0;
         end
      end
      if (cmd.check && !chk_done) begin
         probe_ff <= probe_next;
         try_ff   <= try_ff + CNT_W'(1);
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_state_ff <= st_mem[probe_ff];
         rd_rec_ff   <= rec_mem[probe_ff];
         rd_vld_ff   <= valid_ff[probe_ff];
      end
      if (cmd.check && st_we) st_mem[probe_ff] <= st_wdata;
      if (cmd.check && rec_we) rec_mem[probe_ff] <= '{key: key_ff, len: len_ff,
                                                      adm: adm_ff, birth: birth_ff};
   end

   // result and output registers
   always_ff @(posedge clock) begin
      if (cmd.check && chk_done) begin
         res_status_ff <= chk_status;
         res_idx_ff    <= (chk_status == RES_NOT_FOUND || chk_status == RES_FULL) ?
                          '0 : probe_ff;
         res_fa_ff     <= (chk_status == RES_FOUND) ? rd_rec_ff.adm : '0;
         res_fb_ff     <= (chk_status == RES_FOUND) ? rd_rec_ff.birth : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_idx_ff    <= SLOT_OUT_W'(res_idx_ff);
         out_fa_ff     <= res_fa_ff;
         out_fb_ff     <= res_fb_ff;
         out_used_ff   <= USED_W'(count_ff);
      end
   end

   assign rsp_status          = out_status_ff;
   assign rsp_slot_index      = out_idx_ff;
   assign rsp_found_admission = out_fa_ff;
   assign rsp_found_birth     = out_fb_ff;
   assign rsp_used_count      = out_used_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> (CNT_W'(probe_ff) < n_ff) && (try_ff < n_ff))
      else $error("probe slot or probe count beyond slot count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("occupied count above table depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.check && chk_done && chk_status == RES_INSERTED |=>
      count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not bump occupied count");

   a_search_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.check && mode_ff == MODE_SEARCH |=> $stable(count_ff) && $stable(valid_ff))
      else $error("search changed table state");

endmodule

### rtl/linear_probe_hash_table.sv
// linear_probe_hash_table: top level of the open addressing hash table
// depends on lpht_pkg, lpht_ctrl and lpht_datapath
//
// usage
// - request channel req_*: one item per insert, search or delete; the item
//   is taken at a clock edge with req_valid high and req_stall low
// - response channel rsp_*: exactly one item per request, in request order,
//   taken at a clock edge with rsp_valid high and rsp_stall low
// - csr_wr_en / csr_wr_data set the number of slots in use (clamped to
//   2 .. table depth); write it only while no request is in flight
// - from request to response the block forms the byte sum, runs the remainder
//   unit (two quotient bits per cycle), reads and compares each probed slot
//   through the registered slot memory read (1 .. slot count slots probed),
//   then posts the result
// - a new request is taken the cycle after the result is posted, so the block
//   never takes an item before the last one is through; the probe loop through
//   the single read port of the slot memories sets the spacing of items
// - the response register parts the two sides: a request is accepted while
//   the previous response still waits, and the block holds its next result
//   until rsp_stall drops
// - synchronous reset marks every slot empty at once (per-slot valid flops),
//   clears the occupied count and sets the slot count to 107; no sweep
module linear_probe_hash_table (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [lpht_pkg::SLOTS_W-1:0]          csr_wr_data,
   // request
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lpht_pkg::MODE_W-1:0]           req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]            req_key_text,
   input  logic [lpht_pkg::LEN_W-1:0]            req_key_length,
   input  logic [lpht_pkg::DATE_W-1:0]           req_admission_date,
   input  logic [lpht_pkg::DATE_W-1:0]           req_birth_date,
   // response
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0]         rsp_status,
   output logic [lpht_pkg::SLOT_OUT_W-1:0]       rsp_slot_index,
   output logic [lpht_pkg::DATE_W-1:0]           rsp_found_admission,
   output logic [lpht_pkg::DATE_W-1:0]           rsp_found_birth,
   output logic [lpht_pkg::USED_W-1:0]           rsp_used_count
);
   import lpht_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: accepts items, steps the hash and probe loop, posts results
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: captured item, remainder unit, slot memories, output register
   lpht_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_mode            (req_mode),
      .req_key_text        (req_key_text),
      .req_key_length      (req_key_length),
      .req_admission_date  (req_admission_date),
      .req_birth_date      (req_birth_date),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_found_admission (rsp_found_admission),
      .rsp_found_birth     (rsp_found_birth),
      .rsp_used_count      (rsp_used_count)
   );

endmodule

### sim/tb.sv
// tb: self-checking bench for linear_probe_hash_table (insert, search, delete on a keyed table)
// a predictor class tracks slot contents and checks every response in order
// depends on lpht_pkg and the rtl top level only
`timescale 1ns / 100ps

module tb;
   import lpht_pkg::*;

   // worst request latency: full probe of the largest table
   localparam int LATENCY_MAX     = 7 + 2 * TABLE_DEPTH;
   // cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT     = 20 * LATENCY_MAX;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int PHASES          = 8;
   localparam int POOL            = 20;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // one expected response item
   typedef struct packed {
      result_type              status;
      logic [SLOT_OUT_W-1:0]   slot;
      logic [DATE_W-1:0]       admission;
      logic [DATE_W-1:0]       birth;
      logic [USED_W-1:0]       used;
   } table_answer_type;

   // shadow of the record table; predicts each response and checks it
   class record_table_checker;
      slot_state_type    slot_mark [TABLE_DEPTH];
      logic [KEY_W-1:0]  slot_text [TABLE_DEPTH];
      int                slot_len  [TABLE_DEPTH];
      logic [DATE_W-1:0] slot_adm  [TABLE_DEPTH];
      logic [DATE_W-1:0] slot_bth  [TABLE_DEPTH];
      int                occupied;
      int                slot_count;
      table_answer_type  pending_answers [$];
      int                errors;
      int                answers_checked;
      int                status_tally [5];

      function new();
         foreach (slot_mark[i]) slot_mark[i] = SLOT_EMPTY;
         foreach (status_tally[i]) status_tally[i] = 0;
         occupied        = 0;
         slot_count      = SLOTS_RESET;
         errors          = 0;
         answers_checked = 0;
      endfunction

      function void set_slot_count(logic [SLOTS_W-1:0] value);
         slot_count = value;
      endfunction

      // apply one accepted request to the shadow table and queue its answer
      function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] text,
                                 logic [LEN_W-1:0] len_in, logic [DATE_W-1:0] adm,
                                 logic [DATE_W-1:0] bth);
         table_answer_type ans;
         logic [KEY_W-1:0] key;
         int               n, len, h, s;
         // slot count clamps to 2 .. depth, key length to the key width
         n   = (slot_count < 2) ? 2 : (slot_count > TABLE_DEPTH) ? TABLE_DEPTH : slot_count;
         len = (len_in > KEY_BYTES) ? KEY_BYTES : int'(len_in);
         key = '0;
         h   = 0;
         for (int i = 0; i < len; i++) begin
            key[8*i +: 8] = text[8*i +: 8];
            h = (h + int'(text[8*i +: 8])) % n;
         end
         ans = '0;
         ans.status = RES_NOT_FOUND;
         case (mode)
            MODE_INSERT: begin
               // first empty or tombstone slot, no duplicate check
               ans.status = RES_FULL;
               for (int i = 0; i < n; i++) begin
                  s = (h + i) % n;
                  if (slot_mark[s] != SLOT_USED) begin
                     slot_mark[s] = SLOT_USED;
                     slot_text[s] = key;
                     slot_len[s]  = len;
                     slot_adm[s]  = adm;
                     slot_bth[s]  = bth;
                     occupied++;
                     ans.status = RES_INSERTED;
                     ans.slot   = SLOT_OUT_W'(s);
                     break;
                  end
               end
            end
            MODE_SEARCH, MODE_DELETE: begin
               // stop at a match or an empty slot; tombstones are skipped
               for (int i = 0; i < n; i++) begin
                  s = (h + i) % n;
                  if (slot_mark[s] == SLOT_EMPTY) break;
                  if (slot_mark[s] == SLOT_USED && slot_len[s] == len &&
                      slot_text[s] == key) begin
                     ans.slot = SLOT_OUT_W'(s);
                     if (mode == MODE_SEARCH) begin
                        ans.status    = RES_FOUND;
                        ans.admission = slot_adm[s];
                        ans.birth     = slot_bth[s];
                     end else begin
                        ans.status   = RES_DELETED;
                        slot_mark[s] = SLOT_GONE;
                        if (occupied > 0) occupied--;
                     end
                     break;
                  end
               end
            end
            default: ;
         endcase
         ans.used = USED_W'(occupied);
         pending_answers.push_back(ans);
      endfunction

      function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
         if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
            errors++;
         end
      endfunction

      // compare one accepted response with the oldest queued answer
      function void check_response(logic [STATUS_W-1:0] status, logic [SLOT_OUT_W-1:0] slot,
                                   logic [DATE_W-1:0] adm, logic [DATE_W-1:0] bth,
                                   logic [USED_W-1:0] used);
         table_answer_type ans;
         if (pending_answers.size() == 0) begin
            $display("%0t: response with no request outstanding, status %0d slot %0d",
                     $time, status, slot);
            errors++;
            return;
         end
         ans = pending_answers.pop_front();
         answers_checked++;
         status_tally[int'(ans.status)]++;
         compare_field("status", 32'(ans.status), 32'(status));
         compare_field("slot_index", 32'(ans.slot), 32'(slot));
         compare_field("found_admission", 32'(ans.admission), 32'(adm));
         compare_field("found_birth", 32'(ans.birth), 32'(bth));
         compare_field("used_count", 32'(ans.used), 32'(used));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [SLOTS_W-1:0]    csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode;
   logic [KEY_W-1:0]      req_key_text;
   logic [LEN_W-1:0]      req_key_length;
   logic [DATE_W-1:0]     req_admission_date;
   logic [DATE_W-1:0]     req_birth_date;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [DATE_W-1:0]     rsp_found_admission;
   logic [DATE_W-1:0]     rsp_found_birth;
   logic [USED_W-1:0]     rsp_used_count;

   record_table_checker table_sb;

   // idle percentages for the current phase
   int sender_idle_pct;
   int rsp_stall_pct;
   int requests_sent;
   int settings_used;
   int quiet_cycles = 0;

   // key pool so that searches and deletes hit stored records
   logic [KEY_W-1:0] pool_text [POOL];
   logic [LEN_W-1:0] pool_len  [POOL];

   linear_probe_hash_table u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_key_text        (req_key_text),
      .req_key_length      (req_key_length),
      .req_admission_date  (req_admission_date),
      .req_birth_date      (req_birth_date),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_found_admission (rsp_found_admission),
      .rsp_found_birth     (rsp_found_birth),
      .rsp_used_count      (rsp_used_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // text key packed first character low
   function automatic logic [KEY_W-1:0] key_from_string(string s);
      logic [KEY_W-1:0] k;
      k = '0;
      for (int i = 0; i < s.len() && i < KEY_BYTES; i++) k[8*i +: 8] = s[i];
      return k;
   endfunction

   // mix of letters (case matters) and arbitrary bytes
   function automatic logic [7:0] random_key_byte();
      if ($urandom_range(1)) return 8'($urandom_range(65, 90) + 32 * $urandom_range(1));
      return 8'($urandom_range(255));
   endfunction

   function automatic void refill_pool_entry(int k);
      pool_len[k]  = ($urandom_range(15) == 0) ? 4'd0 : LEN_W'($urandom_range(1, KEY_BYTES));
      pool_text[k] = '0;
      for (int i = 0; i < pool_len[k]; i++) pool_text[k][8*i +: 8] = random_key_byte();
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] text,
                               input logic [LEN_W-1:0] len, input logic [DATE_W-1:0] adm,
                               input logic [DATE_W-1:0] bth);
      // sender gaps: valid stays low while each new draw falls under the idle percentage
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_mode           = mode;
      req_key_text       = text;
      req_key_length     = len;
      req_admission_date = adm;
      req_birth_date     = bth;
      do @(posedge clock); while (req_stall);
      table_sb.note_request(mode, text, len, adm, bth);
      requests_sent++;
      @(negedge clock);
   endtask

   // mostly well-formed traffic on pool keys, the rest arbitrary noise
   task automatic random_request();
      logic [KEY_W-1:0]  text;
      logic [LEN_W-1:0]  len;
      logic [MODE_W-1:0] mode;
      int                k, r;
      if ($urandom_range(99) < 85) begin
         k    = $urandom_range(POOL - 1);
         text = pool_text[k];
         len  = pool_len[k];
         // bytes past the length must be ignored
         if ($urandom_range(1))
            for (int i = len; i < KEY_BYTES; i++) text[8*i +: 8] = 8'($urandom);
         // oversize length acts as a full key
         if (len == KEY_BYTES && $urandom_range(3) == 0) len = LEN_W'($urandom_range(9, 15));
         r    = $urandom_range(99);
         mode = (r < 35) ? MODE_INSERT : (r < 75) ? MODE_SEARCH : MODE_DELETE;
      end else begin
         text = {$urandom, $urandom};
         len  = LEN_W'($urandom_range(15));
         mode = MODE_W'($urandom_range(3));
      end
      send_request(mode, text, len, DATE_W'($urandom), DATE_W'($urandom));
   endtask

   // drop valid and wait until every response is back
   task automatic drain_requests();
      req_valid = 1'b0;
      while (table_sb.pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic write_slot_count(input logic [SLOTS_W-1:0] value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      table_sb.set_slot_count(value);
      settings_used++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // response side: random stall set at the falling edge, check at the rising edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            table_sb.check_response(rsp_status, rsp_slot_index, rsp_found_admission,
                                    rsp_found_birth, rsp_used_count);
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // hang detection: any handshake on either channel clears the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
                  quiet_cycles, table_sb.pending_answers.size());
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0]  key_ab;
      logic [KEY_W-1:0]  key_ba;
      logic [DATE_W-1:0] date_max;
      logic [SLOTS_W-1:0] cfg;
      table_sb           = new();
      sender_idle_pct    = 0;
      rsp_stall_pct      = 0;
      requests_sent      = 0;
      settings_used      = 0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_valid          = 1'b0;
      req_mode           = MODE_INSERT;
      req_key_text       = '0;
      req_key_length     = '0;
      req_admission_date = '0;
      req_birth_date     = '0;
      date_max           = '1;
      key_ab             = key_from_string("Ab");
      key_ba             = key_from_string("bA");
      for (int k = 0; k < POOL; k++) refill_pool_entry(k);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at the reset slot count
      // "Ab", "bA" and "aB" share one hash, so they chain in adjacent slots
      send_request(MODE_INSERT, key_ab, 4'd2, date_max, date_max);
      send_request(MODE_INSERT, key_ba, 4'd2, '0, '0);
      // case differs: walks past both and ends on an empty slot
      send_request(MODE_SEARCH, key_from_string("aB"), 4'd2, '0, '0);
      send_request(MODE_SEARCH, key_ba, 4'd2, '0, '0);
      // junk above the key length
      send_request(MODE_SEARCH, key_ab | {48'hFFFF_FFFF_FFFF, 16'h0}, 4'd2, '0, '0);
      // same bytes plus a zero byte is a different key
      send_request(MODE_SEARCH, key_ab, 4'd3, '0, '0);
      // zero byte inside the key
      send_request(MODE_INSERT, 64'h0000_0000_0042_0041, 4'd3, 27'd20240101, 27'd19991231);
      send_request(MODE_SEARCH, 64'h0000_0000_0042_0041, 4'd3, '0, '0);
      // empty key hashes to slot zero whatever the text
      send_request(MODE_INSERT, '1, 4'd0, 27'd1, date_max);
      send_request(MODE_SEARCH, '0, 4'd0, '0, '0);
      // widest key, then looked up with an oversize length
      send_request(MODE_INSERT, '1, 4'd8, '0, date_max);
      send_request(MODE_SEARCH, '1, 4'd15, '0, '0);
      send_request(MODE_INSERT, '0, 4'd8, date_max, '0);
      send_request(MODE_UNUSED, {$urandom, $urandom}, 4'd5, date_max, date_max);
      // delete leaves a tombstone that search walks over and insert reuses
      send_request(MODE_DELETE, key_ab, 4'd2, '0, '0);
      send_request(MODE_SEARCH, key_ba, 4'd2, '0, '0);
      send_request(MODE_SEARCH, key_ab, 4'd2, '0, '0);
      send_request(MODE_DELETE, key_ab, 4'd2, '0, '0);
      send_request(MODE_INSERT, key_from_string("aB"), 4'd2, 27'd7, 27'd9);

      // shrink to two slots while records sit further up: both slots are used, so inserts report table full
      drain_requests();
      write_slot_count(8'd2);
      send_request(MODE_INSERT, key_from_string("x"), 4'd1, 27'd11, 27'd12);
      send_request(MODE_INSERT, key_from_string("y"), 4'd1, 27'd13, 27'd14);
      send_request(MODE_SEARCH, key_from_string("q"), 4'd1, '0, '0);
      send_request(MODE_DELETE, key_from_string("x"), 4'd1, '0, '0);
      send_request(MODE_INSERT, key_from_string("z"), 4'd1, 27'd15, 27'd16);

      // random phases: slot count and idling change between phases only
      for (int p = 0; p < PHASES; p++) begin
         drain_requests();
         case (p)
            0:       cfg = 8'd0;
            1:       cfg = 8'd128;
            2:       cfg = 8'd255;
            3:       cfg = 8'd1;
            4:       cfg = 8'd17;
            5:       cfg = 8'd3;
            6:       cfg = SLOTS_W'($urandom_range(2, TABLE_DEPTH));
            default: cfg = SLOTS_RESET;
         endcase
         write_slot_count(cfg);
         case (p % 4)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               sender_idle_pct = 57;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 57;
            end
            default: begin
               sender_idle_pct = 22;
               rsp_stall_pct   = 22;
            end
         endcase
         // fresh keys each phase, older ones stay reachable
         for (int k = 0; k < 5; k++) refill_pool_entry($urandom_range(POOL - 1));
         repeat (ITEMS_PER_PHASE) random_request();
      end

      // let everything come back, then watch for stray responses
      drain_requests();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (LATENCY_MAX + 20) @(posedge clock);
      if (table_sb.pending_answers.size() != 0) begin
         $display("%0t: responses outstanding, expected 0, got %0d", $time,
                  table_sb.pending_answers.size());
         table_sb.errors++;
      end

      $display("summary: %0d requests, %0d responses checked, %0d slot-count writes",
               requests_sent, table_sb.answers_checked, settings_used);
      $display("summary: inserted %0d, found %0d, missing %0d, deleted %0d, full %0d",
               table_sb.status_tally[RES_INSERTED], table_sb.status_tally[RES_FOUND],
               table_sb.status_tally[RES_NOT_FOUND], table_sb.status_tally[RES_DELETED],
               table_sb.status_tally[RES_FULL]);
      if (table_sb.errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

### linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_datapath.sv
rtl/linear_probe_hash_table.sv
sim/tb.sv
